// ===== rtl/trfp_pkg.sv =====
// ----------------------------------------------------------------------------
// trfp_pkg
// Types and constants shared by the track fragment run parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package trfp_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned OFFSET_W    = 64;
	localparam int unsigned FLAGS_W     = 24;
	localparam int unsigned TDATA_W     = 160;

	localparam logic [WORD_W-1:0] MIN_RUN_BYTES = 32'd8;
	localparam logic [WORD_W-1:0] WORD_BYTES    = 32'd4;

	// run flag bit positions
	localparam int unsigned FB_DELTA  = 0;
	localparam int unsigned FB_FIRST  = 2;
	localparam int unsigned FB_DUR    = 8;
	localparam int unsigned FB_SIZE   = 9;
	localparam int unsigned FB_SFLAGS = 10;
	localparam int unsigned FB_CTS    = 11;
	localparam logic [WORD_W-1:0] F_RESERVED = 32'hff00_0000;

	// per-sample field slots, ordered as the flag bits above
	localparam logic [1:0] FS_DUR    = 2'd0;
	localparam logic [1:0] FS_SIZE   = 2'd1;
	localparam logic [1:0] FS_SFLAGS = 2'd2;
	localparam logic [1:0] FS_CTS    = 2'd3;

	typedef enum logic [1:0] {
		OP_START_FRAG = 2'd0,
		OP_START_RUN  = 2'd1,
		OP_WORD       = 2'd2,
		OP_FILL       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_INVALID = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_FLAGS   = 3'd1,
		PH_COUNT   = 3'd2,
		PH_DELTA   = 3'd3,
		PH_FIRST   = 3'd4,
		PH_SAMPLES = 3'd5
	} phase_t;

	localparam logic [CFG_INDEX_W-1:0] REG_BASE_OFFSET  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAG_OFFSET  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HDR_DURATION = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HDR_DUR_VLD  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HDR_SIZE     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HDR_FLAGS    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_EXT_DURATION = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_EXT_VLD      = 3'd7;

	typedef struct packed {
		logic [OFFSET_W-1:0] base_offset;
		logic [OFFSET_W-1:0] frag_offset;
		logic [WORD_W-1:0]   hdr_duration;
		logic                hdr_dur_vld;
		logic [WORD_W-1:0]   hdr_size;
		logic [WORD_W-1:0]   ext_duration;
		logic                ext_vld;
	} cfg_t;

	typedef struct packed {
		kind_t               kind;
		logic [OFFSET_W-1:0] sample_offset;
		logic [WORD_W-1:0]   sample_size;
		logic [WORD_W-1:0]   sample_duration;
		logic [WORD_W-1:0]   composition_offset;
		logic                last;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/trfp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// trfp_cfg_regs
// Configuration register file; takes one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trfp_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic [trfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [trfp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output trfp_pkg::cfg_t                         cfg
);

	trfp_pkg::cfg_t cfg_q;

	assign cfg = cfg_q;

	// header default flags are accepted and dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				trfp_pkg::REG_BASE_OFFSET:  cfg_q.base_offset  <= cfg_data;
				trfp_pkg::REG_FRAG_OFFSET:  cfg_q.frag_offset  <= cfg_data;
				trfp_pkg::REG_HDR_DURATION: cfg_q.hdr_duration <= cfg_data[31:0];
				trfp_pkg::REG_HDR_DUR_VLD:  cfg_q.hdr_dur_vld  <= cfg_data[0];
				trfp_pkg::REG_HDR_SIZE:     cfg_q.hdr_size     <= cfg_data[31:0];
				trfp_pkg::REG_EXT_DURATION: cfg_q.ext_duration <= cfg_data[31:0];
				trfp_pkg::REG_EXT_VLD:      cfg_q.ext_vld      <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/trfp_in_reg.sv =====
// ----------------------------------------------------------------------------
// trfp_in_reg
// Input register stage; holds one item until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module trfp_in_reg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    in_op,
	input  wire logic [trfp_pkg::WORD_W-1:0]   in_word,
	input  wire logic                          advance,
	output logic                               valid_s1,
	output trfp_pkg::op_t                      op_s1,
	output logic [trfp_pkg::WORD_W-1:0]        word_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= trfp_pkg::op_t'(in_op);
			word_s1 <= in_word;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/trfp_core.sv =====
// ----------------------------------------------------------------------------
// trfp_core
// Run parser state and result generation for one item per cycle while fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module trfp_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire trfp_pkg::cfg_t                cfg,
	input  wire logic                          fire,
	input  wire trfp_pkg::op_t                 op_s1,
	input  wire logic [trfp_pkg::WORD_W-1:0]   word_s1,
	output logic                               res_valid,
	output trfp_pkg::result_t                  res
);

	trfp_pkg::phase_t                   phase_q, phase_d;
	logic [trfp_pkg::FLAGS_W-1:0]       flags_q, flags_d;
	logic [trfp_pkg::WORD_W-1:0]        samples_q, samples_d;
	logic [trfp_pkg::WORD_W-1:0]        bytes_q, bytes_d;
	logic [trfp_pkg::OFFSET_W-1:0]      offset_q, offset_d;
	logic [1:0]                         fidx_q, fidx_d;
	logic [trfp_pkg::WORD_W-1:0]        dur_q, dur_d;
	logic [trfp_pkg::WORD_W-1:0]        size_q, size_d;
	logic [trfp_pkg::WORD_W-1:0]        comp_q, comp_d;

	logic [3:0]  fld;
	logic [2:0]  n_fields;
	logic [34:0] cnt_prod;
	logic [36:0] need;
	logic [1:0]  sel;
	logic        sel_found;
	logic [2:0]  k;
	logic        hdr_done;
	logic        end_go;
	trfp_pkg::kind_t end_kind;
	logic        sample_go;
	logic [trfp_pkg::WORD_W-1:0] samples_dec;
	logic [trfp_pkg::WORD_W-1:0] bad_first;

	assign fld      = flags_q[trfp_pkg::FB_CTS:trfp_pkg::FB_DUR];
	assign n_fields = 3'(fld[0]) + 3'(fld[1]) + 3'(fld[2]) + 3'(fld[3]);
	assign cnt_prod = 35'(word_s1) * 35'(n_fields);
	assign need     = {cnt_prod, 2'b00}
	                + (flags_q[trfp_pkg::FB_DELTA] ? 37'd4 : 37'd0)
	                + (flags_q[trfp_pkg::FB_FIRST] ? 37'd4 : 37'd0);
	assign bad_first = word_s1 & ((32'd1 << trfp_pkg::FB_FIRST)
	                            | (32'd1 << trfp_pkg::FB_SFLAGS));

	always_comb begin
		sel       = trfp_pkg::FS_DUR;
		sel_found = 1'b0;
		k         = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (fld[i] && !sel_found) begin
				if (k == {1'b0, fidx_q}) begin
					sel       = 2'(i);
					sel_found = 1'b1;
				end else begin
					k = k + 3'd1;
				end
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		flags_d   = flags_q;
		samples_d = samples_q;
		bytes_d   = bytes_q;
		offset_d  = offset_q;
		fidx_d    = fidx_q;
		dur_d     = dur_q;
		size_d    = size_q;
		comp_d    = comp_q;
		hdr_done  = 1'b0;
		end_go    = 1'b0;
		end_kind  = trfp_pkg::KIND_INVALID;
		sample_go = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		case (op_s1)
			trfp_pkg::OP_START_FRAG: begin
				offset_d = cfg.frag_offset;
				phase_d  = trfp_pkg::PH_IDLE;
			end
			trfp_pkg::OP_START_RUN: begin
				if (word_s1 < trfp_pkg::MIN_RUN_BYTES) begin
					end_go = 1'b1;
				end else begin
					bytes_d = word_s1 - trfp_pkg::MIN_RUN_BYTES;
					phase_d = trfp_pkg::PH_FLAGS;
				end
			end
			trfp_pkg::OP_FILL: begin
				if (phase_q == trfp_pkg::PH_SAMPLES && n_fields == 3'd0) begin
					sample_go = 1'b1;
				end
			end
			trfp_pkg::OP_WORD: begin
				case (phase_q)
					trfp_pkg::PH_FLAGS: begin
						if ((word_s1 & trfp_pkg::F_RESERVED) != '0
						    || bad_first == ((32'd1 << trfp_pkg::FB_FIRST)
						                   | (32'd1 << trfp_pkg::FB_SFLAGS))) begin
							end_go = 1'b1;
						end else begin
							flags_d = word_s1[trfp_pkg::FLAGS_W-1:0];
							phase_d = trfp_pkg::PH_COUNT;
						end
					end
					trfp_pkg::PH_COUNT: begin
						if ({5'd0, bytes_q} < need) begin
							end_go = 1'b1;
						end else begin
							samples_d = word_s1;
							if (fld[0]) begin
								dur_d = '0;
							end else if (cfg.hdr_dur_vld) begin
								dur_d = cfg.hdr_duration;
							end else if (cfg.ext_vld) begin
								dur_d = cfg.ext_duration;
							end else begin
								dur_d = '0;
							end
							size_d = cfg.hdr_size;
							comp_d = '0;
							if (flags_q[trfp_pkg::FB_DELTA]) begin
								phase_d = trfp_pkg::PH_DELTA;
							end else if (flags_q[trfp_pkg::FB_FIRST]) begin
								phase_d = trfp_pkg::PH_FIRST;
							end else begin
								hdr_done = 1'b1;
							end
						end
					end
					trfp_pkg::PH_DELTA: begin
						offset_d = cfg.base_offset
						         + {{(trfp_pkg::OFFSET_W-trfp_pkg::WORD_W){word_s1[31]}},
						            word_s1};
						bytes_d  = bytes_q - trfp_pkg::WORD_BYTES;
						if (flags_q[trfp_pkg::FB_FIRST]) begin
							phase_d = trfp_pkg::PH_FIRST;
						end else begin
							hdr_done = 1'b1;
						end
					end
					trfp_pkg::PH_FIRST: begin
						bytes_d  = bytes_q - trfp_pkg::WORD_BYTES;
						hdr_done = 1'b1;
					end
					trfp_pkg::PH_SAMPLES: begin
						if (n_fields != 3'd0) begin
							case (sel)
								trfp_pkg::FS_DUR:  dur_d  = word_s1;
								trfp_pkg::FS_SIZE: size_d = word_s1;
								trfp_pkg::FS_CTS:  comp_d = word_s1;
								default: ;
							endcase
							bytes_d = bytes_q - trfp_pkg::WORD_BYTES;
							if ({1'b0, fidx_q} + 3'd1 >= n_fields) begin
								sample_go = 1'b1;
							end else begin
								fidx_d = fidx_q + 2'd1;
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		if (hdr_done) begin
			if (samples_d == '0) begin
				end_go   = 1'b1;
				end_kind = trfp_pkg::KIND_EMPTY;
			end else begin
				phase_d = trfp_pkg::PH_SAMPLES;
				fidx_d  = 2'd0;
			end
		end

		samples_dec = samples_q - 32'd1;
		if (sample_go) begin
			res_valid              = 1'b1;
			res.kind               = trfp_pkg::KIND_SAMPLE;
			res.sample_offset      = offset_q;
			res.sample_size        = size_d;
			res.sample_duration    = dur_d;
			res.composition_offset = comp_d;
			res.last               = (samples_dec == '0);
			offset_d  = offset_q + {{(trfp_pkg::OFFSET_W-trfp_pkg::WORD_W){1'b0}}, size_d};
			samples_d = samples_dec;
			fidx_d    = 2'd0;
			if (samples_dec == '0) begin
				phase_d = trfp_pkg::PH_IDLE;
			end
		end

		if (end_go) begin
			res_valid = 1'b1;
			res.kind  = end_kind;
			res.last  = 1'b1;
			phase_d   = trfp_pkg::PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= trfp_pkg::PH_IDLE;
			flags_q   <= '0;
			samples_q <= '0;
			bytes_q   <= '0;
			offset_q  <= '0;
			fidx_q    <= '0;
			dur_q     <= '0;
			size_q    <= '0;
			comp_q    <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			flags_q   <= flags_d;
			samples_q <= samples_d;
			bytes_q   <= bytes_d;
			offset_q  <= offset_d;
			fidx_q    <= fidx_d;
			dur_q     <= dur_d;
			size_q    <= size_d;
			comp_q    <= comp_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/trfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// trfp_out_reg
// Result register; holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module trfp_out_reg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            fire,
	input  wire logic                            res_valid,
	input  wire trfp_pkg::result_t               res,
	output logic                                 advance,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [trfp_pkg::TDATA_W-1:0]         out_data,
	output logic [1:0]                           out_user,
	output logic                                 out_last
);

	trfp_pkg::result_t res_q;

	assign advance  = !out_valid || out_ready;
	assign out_data = {res_q.composition_offset, res_q.sample_duration,
	                   res_q.sample_size, res_q.sample_offset};
	assign out_user = res_q.kind;
	assign out_last = res_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/track_fragment_run_parser.sv =====
// ----------------------------------------------------------------------------
// track_fragment_run_parser
// Track fragment run payload parser with per-sample result stream.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, sustained, as long as results are taken;
// every item passes an input register, field selection and a 64-bit offset
// add, and the result register, which holds a result until it is taken.
// Items that produce no result (headers, ignored words) still pass through
// the input register. Configuration writes are taken every cycle and must
// only be made while no item is in flight.
`default_nettype none

module track_fragment_run_parser (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [31:0]                       s_tdata,  // word
	input  wire logic [1:0]                        s_tuser,  // op
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// sample_offset, sample_size, sample_duration, composition_offset
	output logic [trfp_pkg::TDATA_W-1:0]           m_tdata,
	output logic [1:0]                             m_tuser,  // kind
	output logic                                   m_tlast,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [trfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [trfp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	trfp_pkg::cfg_t              cfg;
	trfp_pkg::op_t               op_s1;
	logic [trfp_pkg::WORD_W-1:0] word_s1;
	logic                        valid_s1;
	logic                        advance;
	logic                        fire;
	logic                        res_valid;
	trfp_pkg::result_t           res;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && advance;

	trfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	trfp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_word  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.word_s1  (word_s1)
	);

	trfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (fire),
		.op_s1     (op_s1),
		.word_s1   (word_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	trfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb_track_fragment_run_parser.sv =====
// ----------------------------------------------------------------------------
// tb_track_fragment_run_parser
// Self-checking bench for the track fragment run parser. Stream items are
// fed through a randomly gapped driver, and a clocked model of the parser
// predicts every result. Results are taken with random stalls and compared
// field by field in order. Register settings change between phases while the
// parser is idle. Each phase runs mostly complete runs with random content,
// plus broken runs and stray items.
// ----------------------------------------------------------------------------

module tb_track_fragment_run_parser;

	timeunit 1ns;
	timeprecision 1ps;

	import trfp_pkg::*;

	localparam int N_SETTINGS         = 7;
	localparam int ITEMS_PER_SETTING  = 262;
	localparam int NO_CUT             = 1 << 30;
	localparam int CYCLE_LIMIT        = 600000;
	localparam logic [31:0] FL_DELTA  = 32'h1 << FB_DELTA;
	localparam logic [31:0] FL_FIRST  = 32'h1 << FB_FIRST;
	localparam logic [31:0] FL_DUR    = 32'h1 << FB_DUR;
	localparam logic [31:0] FL_SIZE   = 32'h1 << FB_SIZE;
	localparam logic [31:0] FL_SFLAGS = 32'h1 << FB_SFLAGS;
	localparam logic [31:0] FL_CTS    = 32'h1 << FB_CTS;
	localparam logic [31:0] FL_NOISE  = 32'h00ff_f0fa;

	typedef struct packed {
		op_t         op;
		logic [31:0] word;
	} item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	track_fragment_run_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// parser model state
	cfg_t               run_cfg = '0;
	phase_t             run_phase = PH_IDLE;
	logic [FLAGS_W-1:0] run_flags = '0;
	logic [31:0]        samples_left = '0;
	logic [31:0]        bytes_left = '0;
	logic [63:0]        run_offset = '0;
	logic [1:0]         field_idx = '0;
	logic [31:0]        cur_duration = '0;
	logic [31:0]        cur_size = '0;
	logic [31:0]        cur_cts = '0;

	item_t   item_q[$];
	result_t due_results[$];
	int n_queued = 0;
	int n_taken = 0;
	int mismatches = 0;
	int n_samples = 0;
	int n_empty = 0;
	int n_invalid = 0;
	int cycles = 0;
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	logic cfg_fire = 1'b0;
	int send_gap = 0;
	bit send_calm = 1'b0;
	int take_stall = 0;
	bit take_calm = 1'b0;

	function automatic int per_sample_fields(input logic [FLAGS_W-1:0] f);
		return $countones(f[FB_CTS:FB_DUR]);
	endfunction

	function automatic bit close_run(input kind_t kind, output result_t res);
		res = '0;
		res.kind = kind;
		res.last = 1'b1;
		run_phase = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic bit take_sample(output result_t res);
		res = '0;
		res.kind = KIND_SAMPLE;
		res.sample_offset = run_offset;
		res.sample_size = cur_size;
		res.sample_duration = cur_duration;
		res.composition_offset = cur_cts;
		run_offset = run_offset + {32'b0, cur_size};
		samples_left = samples_left - 1;
		field_idx = '0;
		res.last = (samples_left == 0);
		if (samples_left == 0) run_phase = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic bit after_header(input phase_t from, output result_t res);
		res = '0;
		if (from < PH_DELTA && run_flags[FB_DELTA]) begin
			run_phase = PH_DELTA;
			return 1'b0;
		end
		if (from < PH_FIRST && run_flags[FB_FIRST]) begin
			run_phase = PH_FIRST;
			return 1'b0;
		end
		if (samples_left == 0) return close_run(KIND_EMPTY, res);
		run_phase = PH_SAMPLES;
		field_idx = '0;
		return 1'b0;
	endfunction

	function automatic bit parse_item(input op_t op, input logic [31:0] w,
		output result_t res);
		logic [63:0] need;
		int nf;
		int k;
		logic [1:0] slot;
		bit found;
		res = '0;
		nf = per_sample_fields(run_flags);
		case (op)
			OP_START_FRAG: begin
				run_offset = run_cfg.frag_offset;
				run_phase = PH_IDLE;
				return 1'b0;
			end
			OP_START_RUN: begin
				if (w < MIN_RUN_BYTES) return close_run(KIND_INVALID, res);
				bytes_left = w - MIN_RUN_BYTES;
				run_phase = PH_FLAGS;
				return 1'b0;
			end
			OP_FILL: begin
				if (run_phase == PH_SAMPLES && nf == 0) return take_sample(res);
				return 1'b0;
			end
			default: ;
		endcase
		case (run_phase)
			PH_FLAGS: begin
				if ((w & F_RESERVED) != 0 || (w[FB_FIRST] && w[FB_SFLAGS]))
					return close_run(KIND_INVALID, res);
				run_flags = w[FLAGS_W-1:0];
				run_phase = PH_COUNT;
				return 1'b0;
			end
			PH_COUNT: begin
				need = {32'b0, w} * 64'(4 * nf);
				if (run_flags[FB_DELTA]) need = need + 64'd4;
				if (run_flags[FB_FIRST]) need = need + 64'd4;
				if ({32'b0, bytes_left} < need) return close_run(KIND_INVALID, res);
				samples_left = w;
				if (run_flags[FB_DUR]) cur_duration = '0;
				else if (run_cfg.hdr_dur_vld) cur_duration = run_cfg.hdr_duration;
				else if (run_cfg.ext_vld) cur_duration = run_cfg.ext_duration;
				else cur_duration = '0;
				cur_size = run_cfg.hdr_size;
				cur_cts = '0;
				return after_header(PH_COUNT, res);
			end
			PH_DELTA: begin
				run_offset = run_cfg.base_offset + {{32{w[31]}}, w};
				bytes_left = bytes_left - WORD_BYTES;
				return after_header(PH_DELTA, res);
			end
			PH_FIRST: begin
				bytes_left = bytes_left - WORD_BYTES;
				return after_header(PH_FIRST, res);
			end
			PH_SAMPLES: begin
				if (nf == 0) return 1'b0;
				k = 0;
				found = 1'b0;
				slot = FS_DUR;
				for (int i = 0; i < 4; i++) begin
					if (run_flags[FB_DUR + i]) begin
						if (k == int'(field_idx) && !found) begin
							slot = 2'(i);
							found = 1'b1;
						end
						k++;
					end
				end
				if (slot == FS_DUR) cur_duration = w;
				else if (slot == FS_SIZE) cur_size = w;
				else if (slot == FS_CTS) cur_cts = w;
				bytes_left = bytes_left - WORD_BYTES;
				if (int'(field_idx) + 1 >= nf) return take_sample(res);
				field_idx = field_idx + 2'd1;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void add_item(input op_t op, input logic [31:0] w);
		item_q.push_back('{op, w});
		n_queued++;
	endfunction

	function automatic logic [31:0] field_word();
		case ($urandom_range(0, 15))
			0: return 32'hffff_ffff;
			1: return 32'h0;
			2, 3, 4, 5: return 32'($urandom_range(0, 4095));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_flags();
		logic [31:0] f;
		f = '0;
		if ($urandom_range(0, 1)) f = f | FL_DELTA;
		if ($urandom_range(0, 1)) f = f | FL_FIRST;
		if ($urandom_range(0, 1)) f = f | FL_DUR;
		if ($urandom_range(0, 1)) f = f | FL_SIZE;
		if ($urandom_range(0, 1)) f = f | FL_SFLAGS;
		if ($urandom_range(0, 1)) f = f | FL_CTS;
		if ((f & FL_FIRST) != 0 && (f & FL_SFLAGS) != 0) begin
			if ($urandom_range(0, 1)) f = f & ~FL_FIRST;
			else f = f & ~FL_SFLAGS;
		end
		if ($urandom_range(0, 3) == 0) f = f | ($urandom & FL_NOISE);
		return f;
	endfunction

	// cut truncates the run after that many items
	function automatic int add_run(input logic [31:0] flags, input logic [31:0] count,
		input int slack, input int cut);
		item_t seq[$];
		longint total;
		int nf;
		int reps;
		nf = per_sample_fields(flags[FLAGS_W-1:0]);
		total = longint'(8 + 4 * (int'(flags[FB_DELTA]) + int'(flags[FB_FIRST])))
			+ longint'(count) * 4 * nf + slack;
		seq.push_back('{OP_START_RUN, total[31:0]});
		seq.push_back('{OP_WORD, flags});
		seq.push_back('{OP_WORD, count});
		if (flags[FB_DELTA]) seq.push_back('{OP_WORD, field_word()});
		if (flags[FB_FIRST]) seq.push_back('{OP_WORD, $urandom});
		reps = (count > 8) ? 8 : int'(count);
		repeat (reps) begin
			if (nf == 0) begin
				if ($urandom_range(0, 15) == 0) seq.push_back('{OP_WORD, $urandom});
				seq.push_back('{OP_FILL, $urandom});
			end else begin
				repeat (nf) begin
					if ($urandom_range(0, 15) == 0) seq.push_back('{OP_FILL, $urandom});
					seq.push_back('{OP_WORD, field_word()});
				end
			end
		end
		if (cut < seq.size()) seq = seq[0:cut-1];
		foreach (seq[i]) add_item(seq[i].op, seq[i].word);
		return seq.size();
	endfunction

	function automatic int add_random_sequence();
		logic [31:0] flags;
		int n;
		int choice;
		n = 0;
		flags = pick_flags();
		choice = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			add_item(OP_START_FRAG, $urandom);
			n = 1;
		end
		if (choice < 75)
			return n + add_run(flags, $urandom_range(0, 6), $urandom_range(0, 6), NO_CUT);
		if (choice >= 92) begin
			repeat ($urandom_range(1, 4)) begin
				add_item(op_t'($urandom_range(0, 3)), $urandom);
				n++;
			end
			return n;
		end
		case ($urandom_range(0, 5))
			0: begin
				add_item(OP_START_RUN, $urandom_range(0, 7));
				return n + 1;
			end
			1: return n + add_run(flags | (32'h1 << $urandom_range(24, 31)),
				$urandom_range(0, 3), 0, NO_CUT);
			2: return n + add_run((flags | FL_FIRST | FL_SFLAGS), $urandom_range(0, 3),
				0, NO_CUT);
			3: return n + add_run(flags, $urandom_range(1, 4),
				-int'($urandom_range(1, 8)), NO_CUT);
			4: return n + add_run(flags, $urandom, 0, $urandom_range(1, 12));
			default: return n + add_run(flags, $urandom_range(1, 6), $urandom_range(0, 6),
				$urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [63:0] setting_value(input int mode, input int width);
		logic [63:0] v;
		if (mode == 0) return '0;
		if (mode == 1) v = '1;
		else if ($urandom_range(0, 3) == 0) v = 64'($urandom_range(0, 255));
		else v = {$urandom, $urandom};
		if (width < 64) v = v & ((64'h1 << width) - 1);
		return v;
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid = 1'b0;
		case (idx)
			REG_BASE_OFFSET:  run_cfg.base_offset = val;
			REG_FRAG_OFFSET:  run_cfg.frag_offset = val;
			REG_HDR_DURATION: run_cfg.hdr_duration = val[31:0];
			REG_HDR_DUR_VLD:  run_cfg.hdr_dur_vld = val[0];
			REG_HDR_SIZE:     run_cfg.hdr_size = val[31:0];
			REG_EXT_DURATION: run_cfg.ext_duration = val[31:0];
			REG_EXT_VLD:      run_cfg.ext_vld = val[0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input int mode);
		logic hdr_vld;
		logic ext_vld;
		hdr_vld = (mode == 1) || (mode > 2 && $urandom_range(0, 1));
		ext_vld = (mode == 1) || (mode == 2) || (mode > 2 && $urandom_range(0, 1));
		write_reg(REG_BASE_OFFSET, setting_value(mode, 64));
		write_reg(REG_FRAG_OFFSET, setting_value(mode, 64));
		write_reg(REG_HDR_DURATION, setting_value(mode, 32));
		write_reg(REG_HDR_DUR_VLD, {63'b0, hdr_vld});
		write_reg(REG_HDR_SIZE, setting_value(mode, 32));
		write_reg(REG_HDR_FLAGS, setting_value(mode, 32));
		write_reg(REG_EXT_DURATION, setting_value(mode, 32));
		write_reg(REG_EXT_VLD, {63'b0, ext_vld});
	endtask

	task automatic drain();
		while (n_taken != n_queued || due_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// predict on input transactions, check output transactions
	always @(posedge clk) begin
		result_t want;
		result_t got;
		in_fire <= s_tvalid && s_tready;
		out_fire <= m_tvalid && m_tready;
		cfg_fire <= cfg_valid && cfg_ready;
		if (arst_n && s_tvalid && s_tready) begin
			n_taken++;
			if (parse_item(op_t'(s_tuser), s_tdata, want)) due_results.push_back(want);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = kind_t'(m_tuser);
			got.sample_offset = m_tdata[63:0];
			got.sample_size = m_tdata[95:64];
			got.sample_duration = m_tdata[127:96];
			got.composition_offset = m_tdata[159:128];
			got.last = m_tlast;
			case (got.kind)
				KIND_SAMPLE: n_samples++;
				KIND_EMPTY:  n_empty++;
				default:     n_invalid++;
			endcase
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: kind %0d offset %h last %0d",
						got.kind, got.sample_offset, got.last);
			end else begin
				want = due_results.pop_front();
				if (got.kind !== want.kind || got.sample_offset !== want.sample_offset ||
					got.sample_size !== want.sample_size ||
					got.sample_duration !== want.sample_duration ||
					got.composition_offset !== want.composition_offset ||
					got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch: expected kind %0d off %h size %h dur %h cts %h last %0d",
							want.kind, want.sample_offset, want.sample_size,
							want.sample_duration, want.composition_offset, want.last);
						$display("          actual   kind %0d off %h size %h dur %h cts %h last %0d",
							got.kind, got.sample_offset, got.sample_size,
							got.sample_duration, got.composition_offset, got.last);
					end
				end
			end
		end
	end

	// feed items, holding each until its transaction completes
	always @(negedge clk) begin
		item_t nxt;
		if (!s_tvalid || in_fire) begin
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (item_q.size() != 0) begin
				nxt = item_q.pop_front();
				s_tuser <= nxt.op;
				s_tdata <= nxt.word;
				s_tvalid <= 1'b1;
				if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
				send_gap <= send_calm ? 0 : $urandom_range(0, 11);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_fire) begin
			if ($urandom_range(0, 63) == 0) take_calm = !take_calm;
			take_stall = take_calm ? 0 : $urandom_range(0, 11);
		end
		if (take_stall != 0) begin
			m_tready <= 1'b0;
			take_stall = take_stall - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		int made;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < N_SETTINGS; p++) begin
			load_settings(p);
			if (p == 0) begin
				add_item(OP_WORD, 32'hffff_ffff);
				add_item(OP_FILL, 32'h0);
				add_item(OP_START_FRAG, 32'h0);
				add_item(OP_START_RUN, 32'd7);
				void'(add_run(32'h0, 32'd0, 0, NO_CUT));
				void'(add_run(F_RESERVED, 32'd0, 0, NO_CUT));
				void'(add_run(FL_FIRST | FL_SFLAGS, 32'd1, 0, 2));
				add_item(OP_START_RUN, 32'd8);
				add_item(OP_WORD, FL_DUR | FL_SIZE);
				add_item(OP_WORD, 32'hffff_ffff);
				add_item(OP_START_RUN, 32'd12);
				add_item(OP_WORD, FL_DELTA);
				add_item(OP_WORD, 32'd0);
				add_item(OP_WORD, 32'h8000_0000);
				void'(add_run(FL_FIRST, 32'd2, 0, NO_CUT));
			end
			if ($urandom_range(0, 1)) add_item(OP_START_FRAG, $urandom);
			made = 0;
			while (made < ITEMS_PER_SETTING) made += add_random_sequence();
			drain();
		end
		$display("Sent %0d items under %0d register settings", n_taken, N_SETTINGS);
		$display("Checked %0d samples, %0d empty runs, %0d invalid runs, %0d mismatches",
			n_samples, n_empty, n_invalid, mismatches);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
